// ===== sv/vsl_pkg.sv =====
// Shared constants for the vector step limiter.
// Scale format of the step ratio and the result kind codes.
// No dependencies.
package vsl_pkg;

    localparam int SCALE_FRAC = 24;
    localparam int SCALE_BITS = SCALE_FRAC + 1;

    localparam logic [1:0] KIND_HELD    = 2'd0;
    localparam logic [1:0] KIND_REACHED = 2'd1;
    localparam logic [1:0] KIND_PARTIAL = 2'd2;

endpackage

// ===== sv/vsl_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// A sideband vector travels with each beat. Stands alone, no package use.
module vsl_sqrt #(
    parameter int IN_W   = 50,
    parameter int OUT_W  = 25,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [OUT_W-1:0]  root,
    output logic [SIDE_W-1:0] out_side
);

    logic [OUT_W:1]    valid_reg;
    logic [IN_W-1:0]   rem_reg  [1:OUT_W];
    logic [OUT_W-1:0]  root_reg [1:OUT_W];
    logic [SIDE_W-1:0] side_reg [1:OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;

        logic              v_i;
        logic [IN_W-1:0]   rem_i;
        logic [OUT_W-1:0]  root_i;
        logic [SIDE_W-1:0] side_i;
        logic [IN_W-1:0]   trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_i    = in_valid;
            assign rem_i  = radicand;
            assign root_i = '0;
            assign side_i = in_side;
        end
        else begin : g_next
            assign v_i    = valid_reg[k];
            assign rem_i  = rem_reg[k];
            assign root_i = root_reg[k];
            assign side_i = side_reg[k];
        end

        assign trial = (IN_W'(root_i) << (B + 1)) | (IN_W'(1) << (2 * B));
        assign take  = rem_i >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_i - trial : rem_i;
                root_reg[k+1] <= take ? (root_i | (OUT_W'(1) << B)) : root_i;
                side_reg[k+1] <= side_i;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W];
    assign root      = root_reg[OUT_W];
    assign out_side  = side_reg[OUT_W];

endmodule

// ===== sv/vsl_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in Q_W bits. Sideband travels with each beat.
module vsl_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 25,
    parameter int Q_W    = 25,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numer,
    input  logic [DEN_W-1:0]  denom,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W:1]      valid_reg;
    logic [RW-1:0]     rem_reg  [1:Q_W];
    logic [DEN_W-1:0]  den_reg  [1:Q_W];
    logic [Q_W-1:0]    quot_reg [1:Q_W];
    logic [SIDE_W-1:0] side_reg [1:Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;

        logic              v_i;
        logic [RW-1:0]     rem_i;
        logic [DEN_W-1:0]  den_i;
        logic [Q_W-1:0]    quot_i;
        logic [SIDE_W-1:0] side_i;
        logic [RW-1:0]     trial;
        logic              take;

        if (k == 0) begin : g_first
            assign v_i    = in_valid;
            assign rem_i  = RW'(numer);
            assign den_i  = denom;
            assign quot_i = '0;
            assign side_i = in_side;
        end
        else begin : g_next
            assign v_i    = valid_reg[k];
            assign rem_i  = rem_reg[k];
            assign den_i  = den_reg[k];
            assign quot_i = quot_reg[k];
            assign side_i = side_reg[k];
        end

        assign trial = RW'(den_i) << B;
        assign take  = rem_i >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= v_i;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_i - trial : rem_i;
                den_reg[k+1]  <= den_i;
                quot_reg[k+1] <= take ? (quot_i | (Q_W'(1) << B)) : quot_i;
                side_reg[k+1] <= side_i;
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign quot      = quot_reg[Q_W];
    assign out_side  = side_reg[Q_W];

endmodule

// ===== sv/vector_step_limiter.sv =====
// Vector step limiter top level: moves a 3D fixed-point point toward a target.
// Uses vsl_pkg, vsl_sqrt and vsl_div.
//
// Takes one beat per cycle while in_stall is low and returns one result per beat,
// in order, through three front stages (difference, squares, compare), one stage
// per root bit in the square root, one per scale bit in the divider, then the
// multiply and the output register.
// A skid register behind the output register catches the beat in flight when
// the output stalls; the pipeline holds only while the skid register is full,
// and in_stall comes straight from that register.
module vector_step_limiter #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] current_x,
    input  logic signed [COORD_BITS-1:0] current_y,
    input  logic signed [COORD_BITS-1:0] current_z,
    input  logic signed [COORD_BITS-1:0] target_x,
    input  logic signed [COORD_BITS-1:0] target_y,
    input  logic signed [COORD_BITS-1:0] target_z,
    input  logic        [COORD_BITS-1:0] step_limit,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] next_x,
    output logic signed [COORD_BITS-1:0] next_y,
    output logic signed [COORD_BITS-1:0] next_z,
    output logic        [1:0]            move_kind
);

    localparam int C       = COORD_BITS;
    localparam int QB      = vsl_pkg::SCALE_BITS;
    localparam int SQ_SIDE = 2 + 6 * C + 3 + C;
    localparam int DV_SIDE = 2 + 6 * C + 3;

    logic en;
    logic [2:0][C-1:0] cur_in;
    logic [2:0][C-1:0] tgt_in;

    // skid register behind the output register
    logic              sk_valid_reg;
    logic [1:0]        sk_kind_reg;
    logic [2:0][C-1:0] sk_res_reg;

    assign en       = !sk_valid_reg;
    assign in_stall = sk_valid_reg;
    assign cur_in   = {current_z, current_y, current_x};
    assign tgt_in   = {target_z, target_y, target_x};

    // stage 1: differences
    logic              s1_valid_reg;
    logic [2:0][C-1:0] s1_cur_reg, s1_tgt_reg, s1_mag_reg;
    logic [2:0]        s1_sgn_reg;
    logic [C-1:0]      s1_limit_reg;
    logic [2:0][C-1:0] s1_mag_next;
    logic [2:0]        s1_sgn_next;

    always_comb
    begin
        logic signed [C:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d = $signed({tgt_in[i][C-1], tgt_in[i]}) - $signed({cur_in[i][C-1], cur_in[i]});
            s1_sgn_next[i] = d[C];
            s1_mag_next[i] = d[C] ? C'(-d) : C'(d);
        end
    end

    // stage 2: squares
    logic              s2_valid_reg;
    logic [2:0][C-1:0] s2_cur_reg, s2_tgt_reg, s2_mag_reg;
    logic [2:0]        s2_sgn_reg;
    logic [C-1:0]      s2_limit_reg;
    logic [2:0][2*C-1:0] s2_sq_reg;
    logic [2*C-1:0]    s2_lsq_reg;

    // stage 3: distance compare and kind
    logic              s3_valid_reg;
    logic [1:0]        s3_kind_reg;
    logic [2:0][C-1:0] s3_base_reg, s3_mag_reg;
    logic [2:0]        s3_sgn_reg;
    logic [C-1:0]      s3_limit_reg;
    logic [2*C+1:0]    s3_dsq_reg;
    logic [2*C+1:0]    s3_dsq_next;
    logic [1:0]        s3_kind_next;

    always_comb
    begin
        s3_dsq_next = (2*C+2)'(s2_sq_reg[0]) + (2*C+2)'(s2_sq_reg[1])
                    + (2*C+2)'(s2_sq_reg[2]);
        priority if (s2_limit_reg == '0)
            s3_kind_next = vsl_pkg::KIND_HELD;
        else if (s3_dsq_next <= (2*C+2)'(s2_lsq_reg))
            s3_kind_next = vsl_pkg::KIND_REACHED;
        else
            s3_kind_next = vsl_pkg::KIND_PARTIAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cur_reg   <= cur_in;
            s1_tgt_reg   <= tgt_in;
            s1_mag_reg   <= s1_mag_next;
            s1_sgn_reg   <= s1_sgn_next;
            s1_limit_reg <= step_limit;

            s2_cur_reg   <= s1_cur_reg;
            s2_tgt_reg   <= s1_tgt_reg;
            s2_mag_reg   <= s1_mag_reg;
            s2_sgn_reg   <= s1_sgn_reg;
            s2_limit_reg <= s1_limit_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_sq_reg[i] <= (2*C)'(s1_mag_reg[i]) * (2*C)'(s1_mag_reg[i]);
            end
            s2_lsq_reg   <= (2*C)'(s1_limit_reg) * (2*C)'(s1_limit_reg);

            s3_kind_reg  <= s3_kind_next;
            s3_base_reg  <= (s3_kind_next == vsl_pkg::KIND_REACHED) ? s2_tgt_reg : s2_cur_reg;
            s3_mag_reg   <= s2_mag_reg;
            s3_sgn_reg   <= s2_sgn_reg;
            s3_limit_reg <= s2_limit_reg;
            s3_dsq_reg   <= s3_dsq_next;
        end
    end

    // square root of the squared distance
    logic               sq_valid;
    logic [C:0]         sq_root;
    logic [SQ_SIDE-1:0] sq_side;
    logic [1:0]         sq_kind;
    logic [2:0][C-1:0]  sq_base, sq_mag;
    logic [2:0]         sq_sgn;
    logic [C-1:0]       sq_limit;

    vsl_sqrt #(
        .IN_W   (2 * C + 2),
        .OUT_W  (C + 1),
        .SIDE_W (SQ_SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .radicand  (s3_dsq_reg),
        .in_side   ({s3_kind_reg, s3_base_reg, s3_sgn_reg, s3_mag_reg, s3_limit_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_side)
    );

    assign {sq_kind, sq_base, sq_sgn, sq_mag, sq_limit} = sq_side;

    // scale = limit * 2^SCALE_FRAC / dist
    logic               dv_valid;
    logic [QB-1:0]      dv_quot;
    logic [DV_SIDE-1:0] dv_side;
    logic [1:0]         dv_kind;
    logic [2:0][C-1:0]  dv_base, dv_mag;
    logic [2:0]         dv_sgn;

    vsl_div #(
        .NUM_W  (C + vsl_pkg::SCALE_FRAC),
        .DEN_W  (C + 1),
        .Q_W    (QB),
        .SIDE_W (DV_SIDE)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .numer     ({sq_limit, {vsl_pkg::SCALE_FRAC{1'b0}}}),
        .denom     (sq_root),
        .in_side   ({sq_kind, sq_base, sq_sgn, sq_mag}),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .out_side  (dv_side)
    );

    assign {dv_kind, dv_base, dv_sgn, dv_mag} = dv_side;

    // multiply stage
    logic              mu_valid_reg;
    logic [1:0]        mu_kind_reg;
    logic [2:0][C-1:0] mu_base_reg, mu_step_reg;
    logic [2:0]        mu_sgn_reg;
    logic [2:0][C+QB-1:0] mu_prod;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mu_prod[i] = (C+QB)'(dv_mag[i]) * (C+QB)'(dv_quot);
        end
    end

    // output register
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [2:0][C-1:0] out_res_reg;
    logic [2:0][C-1:0] out_res_next;
    logic              out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (mu_kind_reg == vsl_pkg::KIND_PARTIAL)
                out_res_next[i] = mu_base_reg[i]
                                + (mu_sgn_reg[i] ? (~mu_step_reg[i] + C'(1)) : mu_step_reg[i]);
            else
                out_res_next[i] = mu_base_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mu_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                mu_valid_reg <= dv_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= sk_valid_reg || mu_valid_reg;
                sk_valid_reg  <= 1'b0;
            end
            else if (en && mu_valid_reg)
            begin
                sk_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mu_kind_reg <= dv_kind;
            mu_base_reg <= dv_base;
            mu_sgn_reg  <= dv_sgn;
            for (int i = 0; i < 3; i++)
            begin
                mu_step_reg[i] <= mu_prod[i][C+vsl_pkg::SCALE_FRAC-1:vsl_pkg::SCALE_FRAC];
            end
        end
        if (out_free)
        begin
            out_kind_reg <= sk_valid_reg ? sk_kind_reg : mu_kind_reg;
            out_res_reg  <= sk_valid_reg ? sk_res_reg : out_res_next;
        end
        else if (en)
        begin
            sk_kind_reg <= mu_kind_reg;
            sk_res_reg  <= out_res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_x    = out_res_reg[0];
    assign next_y    = out_res_reg[1];
    assign next_z    = out_res_reg[2];
    assign move_kind = out_kind_reg;

endmodule
